>>> design/ctok_pkg.sv
// Shared types, constants and character helpers for the C subset tokenizer.
// No dependencies; used by ctok_fifo and c_subset_tokenizer_core.
package ctok_pkg;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_INT      = 4'd0;
    localparam kind_t KIND_RETURN   = 4'd1;
    localparam kind_t KIND_IDENT    = 4'd2;
    localparam kind_t KIND_INTEGER  = 4'd3;
    localparam kind_t KIND_UNKNOWN  = 4'd4;
    localparam kind_t KIND_SYM_BASE = 4'd5;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Output queue: four entries; a byte is accepted only while two are free
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Symbol lookup: bit 4 = hit, bits 3:0 = index into ( ) { } ; ! ~ - * / +
    function automatic logic [4:0] symbol_lookup(input logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            8'h28:   r = {1'b1, 4'd0};
            8'h29:   r = {1'b1, 4'd1};
            8'h7B:   r = {1'b1, 4'd2};
            8'h7D:   r = {1'b1, 4'd3};
            8'h3B:   r = {1'b1, 4'd4};
            8'h21:   r = {1'b1, 4'd5};
            8'h7E:   r = {1'b1, 4'd6};
            8'h2D:   r = {1'b1, 4'd7};
            8'h2A:   r = {1'b1, 4'd8};
            8'h2F:   r = {1'b1, 4'd9};
            8'h2B:   r = {1'b1, 4'd10};
            default: r = {1'b0, 4'd0};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_int_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0:    r = 8'h69;  // i
            2'd1:    r = 8'h6E;  // n
            2'd2:    r = 8'h74;  // t
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_return_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = 8'h72;  // r
            3'd1:    r = 8'h65;  // e
            3'd2:    r = 8'h74;  // t
            3'd3:    r = 8'h75;  // u
            3'd4:    r = 8'h72;  // r
            3'd5:    r = 8'h6E;  // n
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> design/c_subset_tokenizer_core.sv
// Streaming tokenizer for a small C subset: word tracking, classification, token queue.
// Depends on ctok_pkg and ctok_fifo.
//
// Usage:
//   Input channel in_valid/in_ready carries one source byte (char_code) per
//   transfer, with end_of_source set on the final byte of a source. Newline
//   bytes are dropped; whitespace and the symbols ( ) { } ; ! ~ - * / + end a
//   word, and every symbol is a token of its own.
//   Output channel out_valid/out_ready carries one token per transfer: kind,
//   start offset, length and last_in_run, which marks the last token caused
//   by one input byte. A byte yields zero, one or two tokens (word, then symbol).
//   Throughput: one byte per cycle while the receiver keeps up; the output
//   port moves one token per cycle, so bytes that yield two tokens drain
//   more slowly. A token enters the queue when its byte is accepted and is
//   presented once it reaches the head. in_ready drops when the four-entry queue
//   cannot take two more tokens, so a stalled receiver back-pressures the input.
//   Reset clears position, word state and the queue; end_of_source returns
//   the word tracker to the same state, so the next byte starts at offset 0.
module c_subset_tokenizer_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_in_run
);

    logic [POSITION_BITS-1:0] byte_position_reg, byte_position_next;
    logic [POSITION_BITS-1:0] word_start_reg, word_start_next;
    logic [15:0]              word_length_reg, word_length_next;
    logic                     word_open_reg, word_open_next;
    logic                     all_digits_reg, all_digits_next;
    logic                     ident_shape_reg, ident_shape_next;
    logic                     int_match_reg, int_match_next;
    logic                     ret_match_reg, ret_match_next;

    // Word state after this byte is folded in (equals current for non-word bytes)
    logic [POSITION_BITS-1:0] s1_start;
    logic [15:0]              s1_length;
    logic                     s1_open, s1_digits, s1_ident, s1_int, s1_ret;

    logic       accept;
    logic       c_newline, c_space, c_sym, c_word, c_digit, c_alpha;
    logic [4:0] sym_info;
    logic       word_tok_v;

    ctok_pkg::kind_t  word_kind;
    ctok_pkg::token_t word_tok, sym_tok, tok_a;
    ctok_pkg::token_t head_tok;
    logic             fifo_room;

    assign accept    = in_valid && in_ready;
    assign sym_info  = ctok_pkg::symbol_lookup(char_code);
    assign c_newline = (char_code == ctok_pkg::CH_NEWLINE);
    assign c_space   = ctok_pkg::is_space(char_code);
    assign c_sym     = sym_info[4];
    assign c_word    = !c_newline && !c_space && !c_sym;
    assign c_digit   = ctok_pkg::is_digit(char_code);
    assign c_alpha   = ctok_pkg::is_alpha(char_code);

    always_comb
    begin
        s1_start  = word_start_reg;
        s1_length = word_length_reg;
        s1_open   = word_open_reg;
        s1_digits = all_digits_reg;
        s1_ident  = ident_shape_reg;
        s1_int    = int_match_reg;
        s1_ret    = ret_match_reg;
        if (c_word)
        begin
            s1_open = 1'b1;
            if (!word_open_reg)
            begin
                s1_start = byte_position_reg;
            end
            s1_digits = all_digits_reg && c_digit;
            if (word_length_reg == '0)
            begin
                s1_ident = c_alpha;
            end
            else
            begin
                s1_ident = ident_shape_reg
                        && (c_alpha || c_digit || (char_code == 8'h5F));
            end
            s1_int = int_match_reg && (word_length_reg < 16'd3)
                  && (ctok_pkg::kw_int_char(word_length_reg[1:0]) == char_code);
            s1_ret = ret_match_reg && (word_length_reg < 16'd6)
                  && (ctok_pkg::kw_return_char(word_length_reg[2:0]) == char_code);
            if (word_length_reg != ctok_pkg::LEN_MAX)
            begin
                s1_length = word_length_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        priority if (s1_int && (s1_length == 16'd3))
        begin
            word_kind = ctok_pkg::KIND_INT;
        end
        else if (s1_ret && (s1_length == 16'd6))
        begin
            word_kind = ctok_pkg::KIND_RETURN;
        end
        else if (s1_ident)
        begin
            word_kind = ctok_pkg::KIND_IDENT;
        end
        else if (s1_digits)
        begin
            word_kind = ctok_pkg::KIND_INTEGER;
        end
        else
        begin
            word_kind = ctok_pkg::KIND_UNKNOWN;
        end
    end

    // Word flushes on a delimiter, or at end of source after this byte
    assign word_tok_v = s1_open && (c_space || c_sym || end_of_source);

    always_comb
    begin
        word_tok.kind   = word_kind;
        word_tok.start  = 16'(32'(s1_start));
        word_tok.length = s1_length;
        word_tok.last   = !c_sym;

        sym_tok.kind    = ctok_pkg::KIND_SYM_BASE + sym_info[3:0];
        sym_tok.start   = 16'(32'(byte_position_reg));
        sym_tok.length  = 16'd1;
        sym_tok.last    = 1'b1;

        tok_a = word_tok_v ? word_tok : sym_tok;
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        word_start_next    = word_start_reg;
        word_length_next   = word_length_reg;
        word_open_next     = word_open_reg;
        all_digits_next    = all_digits_reg;
        ident_shape_next   = ident_shape_reg;
        int_match_next     = int_match_reg;
        ret_match_next     = ret_match_reg;
        if (accept)
        begin
            if (end_of_source || c_space || c_sym)
            begin
                word_start_next  = '0;
                word_length_next = '0;
                word_open_next   = 1'b0;
                all_digits_next  = 1'b1;
                ident_shape_next = 1'b1;
                int_match_next   = 1'b1;
                ret_match_next   = 1'b1;
            end
            else
            begin
                word_start_next  = s1_start;
                word_length_next = s1_length;
                word_open_next   = s1_open;
                all_digits_next  = s1_digits;
                ident_shape_next = s1_ident;
                int_match_next   = s1_int;
                ret_match_next   = s1_ret;
            end
            byte_position_next = end_of_source ? '0 : byte_position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            word_start_reg    <= '0;
            word_length_reg   <= '0;
            word_open_reg     <= 1'b0;
            all_digits_reg    <= 1'b1;
            ident_shape_reg   <= 1'b1;
            int_match_reg     <= 1'b1;
            ret_match_reg     <= 1'b1;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            word_start_reg    <= word_start_next;
            word_length_reg   <= word_length_next;
            word_open_reg     <= word_open_next;
            all_digits_reg    <= all_digits_next;
            ident_shape_reg   <= ident_shape_next;
            int_match_reg     <= int_match_next;
            ret_match_reg     <= ret_match_next;
        end
    end

    ctok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (accept && (word_tok_v || c_sym)),
        .push_b    (accept && word_tok_v && c_sym),
        .data_a    (tok_a),
        .data_b    (sym_tok),
        .room      (fifo_room),
        .not_empty (out_valid),
        .pop       (out_ready),
        .head      (head_tok)
    );

    assign in_ready     = fifo_room;
    assign token_kind   = head_tok.kind;
    assign token_start  = head_tok.start;
    assign token_length = head_tok.length;
    assign last_in_run  = head_tok.last;

endmodule

>>> design/ctok_fifo.sv
// Small token queue: up to two writes and one read per cycle, registered head.
// Depends on ctok_pkg (token_t, depth constants).
module ctok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  logic              push_b,
    input  ctok_pkg::token_t  data_a,
    input  ctok_pkg::token_t  data_b,
    output logic              room,
    output logic              not_empty,
    input  logic              pop,
    output ctok_pkg::token_t  head
);

    ctok_pkg::token_t mem_reg [ctok_pkg::FIFO_DEPTH];

    logic [ctok_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ctok_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ctok_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [ctok_pkg::FIFO_PTR_W-1:0] wr_ptr_b;
    logic                            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= ctok_pkg::FIFO_CNT_W'(ctok_pkg::FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_a && push_b)
        begin
            wr_ptr_next = wr_ptr_reg + 2'd2;
        end
        else if (push_a)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg
                    + ctok_pkg::FIFO_CNT_W'(push_a)
                    + ctok_pkg::FIFO_CNT_W'(push_a && push_b)
                    - ctok_pkg::FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_a && push_b)
        begin
            mem_reg[wr_ptr_b] <= data_b;
        end
    end

endmodule
